FILE: hdl/x86_port_io_decode_core_macros.svh
// Assertion macros used by the port I/O decode core.
`ifndef X86_PORT_IO_DECODE_CORE_MACROS_SVH
`define X86_PORT_IO_DECODE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define X86_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define X86_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/x86pio_pkg.sv
// Package with opcode constants, size codes and payload types for the port I/O decoder.
`timescale 1ns / 1ps

package x86pio_pkg;

   // Opcode bytes of the recognized instructions and prefixes.
   localparam logic [7:0] OP_IN_DX_B   = 8'hEC;
   localparam logic [7:0] OP_IN_DX_D   = 8'hED;
   localparam logic [7:0] OP_OUT_DX_B  = 8'hEE;
   localparam logic [7:0] OP_OUT_DX_D  = 8'hEF;
   localparam logic [7:0] OP_INS_B     = 8'h6C;
   localparam logic [7:0] OP_INS_D     = 8'h6D;
   localparam logic [7:0] OP_OUTS_B    = 8'h6E;
   localparam logic [7:0] OP_OUTS_D    = 8'h6F;
   localparam logic [7:0] OP_IN_IMM_B  = 8'hE4;
   localparam logic [7:0] OP_IN_IMM_D  = 8'hE5;
   localparam logic [7:0] OP_OUT_IMM_B = 8'hE6;
   localparam logic [7:0] OP_OUT_IMM_D = 8'hE7;
   localparam logic [7:0] OP_CLI       = 8'hFA;
   localparam logic [7:0] OP_STI       = 8'hFB;
   localparam logic [7:0] PFX_OPSIZE   = 8'h66;
   localparam logic [7:0] PFX_REP      = 8'hF3;

   // Access size codes (log2 of the number of ports touched).
   localparam logic [4:0] SIZE_BYTE  = 5'd0;
   localparam logic [4:0] SIZE_WORD  = 5'd1;
   localparam logic [4:0] SIZE_DWORD = 5'd2;
   localparam logic [4:0] SIZE_ALL   = 5'd16;

   // Reset value of the user address limit.
   localparam logic [63:0] USER_LIMIT_RESET = 64'h0000_7FFF_FFFF_FFFF;

   // One instruction to decode.
   typedef struct packed {
      logic [63:0] instr_address;
      logic [7:0]  opcode_byte0;
      logic [7:0]  opcode_byte1;
      logic [7:0]  opcode_byte2;
      logic [15:0] dx_value;
   } x86pio_req_type;

   // One decode result.
   typedef struct packed {
      logic        decode_ok;
      logic [15:0] io_port;
      logic [4:0]  size_log2;
   } x86pio_rsp_type;

endpackage

FILE: hdl/x86pio_req_if.sv
// Valid/ready channel carrying one instruction item into the decoder.
`timescale 1ns / 1ps

interface x86pio_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] instr_address;
   logic [7:0]  opcode_byte0;
   logic [7:0]  opcode_byte1;
   logic [7:0]  opcode_byte2;
   logic [15:0] dx_value;

   modport source (
      output valid, instr_address, opcode_byte0, opcode_byte1, opcode_byte2, dx_value,
      input  ready
   );
   modport sink (
      input  valid, instr_address, opcode_byte0, opcode_byte1, opcode_byte2, dx_value,
      output ready
   );
endinterface

FILE: hdl/x86pio_rsp_if.sv
// Valid/ready channel carrying one decode result item out of the decoder.
`timescale 1ns / 1ps

interface x86pio_rsp_if;
   logic        valid;
   logic        ready;
   logic        decode_ok;
   logic [15:0] io_port;
   logic [4:0]  size_log2;

   modport source (
      output valid, decode_ok, io_port, size_log2,
      input  ready
   );
   modport sink (
      input  valid, decode_ok, io_port, size_log2,
      output ready
   );
endinterface

FILE: hdl/x86pio_decode.sv
// Combinational decode of one port I/O instruction into port, size and status.
`timescale 1ns / 1ps

module x86pio_decode
   import x86pio_pkg::*;
#(
   parameter int NUM_PORTS = 65536
) (
   input  x86pio_req_type req,
   input  logic [63:0]    user_limit,
   input  logic [63:0]    user_limit_m1,
   output x86pio_rsp_type rsp
);

   localparam logic [17:0] PortCountVal = 18'(NUM_PORTS);

   logic        below_lim;
   logic        below_lim_m1;
   logic        prefix_pair;
   logic        single_prefix;
   logic        hit;
   logic        ranged;
   logic [15:0] port;
   logic [4:0]  size;
   logic [17:0] span;
   logic [17:0] port_end;
   logic        in_range;

   // Address and prefix checks for two- and three-byte forms.
   assign below_lim     = req.instr_address < user_limit;
   assign below_lim_m1  = req.instr_address < user_limit_m1;
   assign prefix_pair   = ((req.opcode_byte0 == PFX_REP) &&
                           (req.opcode_byte1 == PFX_OPSIZE)) ||
                          ((req.opcode_byte0 == PFX_OPSIZE) &&
                           (req.opcode_byte1 == PFX_REP));
   assign single_prefix = (req.opcode_byte0 == PFX_OPSIZE) || (req.opcode_byte0 == PFX_REP);

   // Opcode decode; one-byte forms first, then the longer forms in priority order.
   always_comb begin
      hit    = 1'b0;
      ranged = 1'b0;
      port   = '0;
      size   = SIZE_BYTE;
      unique case (req.opcode_byte0) inside
         OP_IN_DX_B, OP_INS_B, OP_OUT_DX_B, OP_OUTS_B: begin
            hit  = 1'b1;
            port = req.dx_value;
         end
         OP_IN_DX_D, OP_INS_D, OP_OUT_DX_D, OP_OUTS_D: begin
            hit    = 1'b1;
            ranged = 1'b1;
            port   = req.dx_value;
            size   = SIZE_DWORD;
         end
         OP_CLI, OP_STI: begin
            hit  = 1'b1;
            size = SIZE_ALL;
         end
         default: begin
            if (below_lim) begin
               // Immediate-port forms.
               unique case (req.opcode_byte0) inside
                  OP_IN_IMM_B, OP_OUT_IMM_B: begin
                     hit  = 1'b1;
                     port = {8'd0, req.opcode_byte1};
                  end
                  OP_IN_IMM_D, OP_OUT_IMM_D: begin
                     hit    = 1'b1;
                     ranged = 1'b1;
                     port   = {8'd0, req.opcode_byte1};
                     size   = SIZE_DWORD;
                  end
                  default: ;
               endcase

               // Operand-size prefix selects the word forms.
               if (req.opcode_byte0 == PFX_OPSIZE) begin
                  unique case (req.opcode_byte1) inside
                     OP_IN_DX_D, OP_OUT_DX_D, OP_INS_D, OP_OUTS_D: begin
                        hit    = 1'b1;
                        ranged = 1'b1;
                        port   = req.dx_value;
                        size   = SIZE_WORD;
                     end
                     OP_IN_IMM_D, OP_OUT_IMM_D: begin
                        hit    = 1'b1;
                        ranged = 1'b1;
                        port   = {8'd0, req.opcode_byte2};
                        size   = SIZE_WORD;
                     end
                     default: ;
                  endcase
               end

               // A single prefix before a string instruction.
               if (!hit && single_prefix) begin
                  unique case (req.opcode_byte1) inside
                     OP_INS_B, OP_OUTS_B: begin
                        hit  = 1'b1;
                        port = req.dx_value;
                     end
                     OP_INS_D, OP_OUTS_D: begin
                        hit    = 1'b1;
                        ranged = 1'b1;
                        port   = req.dx_value;
                        size   = SIZE_DWORD;
                     end
                     default: ;
                  endcase
               end

               // Both prefixes before a word string instruction.
               if (!hit && below_lim_m1 && prefix_pair &&
                   ((req.opcode_byte2 == OP_INS_D) || (req.opcode_byte2 == OP_OUTS_D))) begin
                  hit    = 1'b1;
                  ranged = 1'b1;
                  port   = req.dx_value;
                  size   = SIZE_WORD;
               end
            end
         end
      endcase
   end

   // Wide accesses must end within the port space.
   assign span     = 18'd1 << size[1:0];
   assign port_end = {2'b00, port} + span;
   assign in_range = !ranged || (port_end <= PortCountVal);

   // Failed decodes report port and size as zero.
   always_comb begin
      rsp.decode_ok = hit && in_range;
      rsp.io_port   = rsp.decode_ok ? port : 16'd0;
      rsp.size_log2 = rsp.decode_ok ? size : SIZE_BYTE;
   end

endmodule

FILE: hdl/x86_port_io_decode_core.sv
// Top level of the x86 port I/O instruction decoder with input and result registers.
//
//   channel | direction | handshake       | payload
//   --------+-----------+-----------------+-----------------------------------------------
//   req     | in        | valid/ready     | instr_address, opcode_byte0..2, dx_value
//   rsp     | out       | valid/ready     | decode_ok, io_port, size_log2
//   csr     | in        | write enable    | user_address_limit (64 bits)
//
// One item is accepted per cycle while the result is not stalled; results are registered.
// The decode sits between the input register and the result register.
// Reset is synchronous and active high; it empties both stages and restores the limit.
// A stalled result holds the result register; the input register accepts while it is
// empty or its item can move into the result register in the same cycle.
`timescale 1ns / 1ps
`include "x86_port_io_decode_core_macros.svh"

module x86_port_io_decode_core
   import x86pio_pkg::*;
#(
   parameter int NUM_PORTS = 65536
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [63:0]   csr_wdata,
   x86pio_req_if.sink    req_port,
   x86pio_rsp_if.source  rsp_port
);

   logic           s1_valid_ff;
   logic           s1_valid_in;
   x86pio_req_type s1_data_ff;
   x86pio_req_type req_data;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   x86pio_rsp_type rsp_data_ff;
   x86pio_rsp_type dec_rsp;
   logic [63:0]    limit_ff;
   logic [63:0]    limit_m1_ff;
   logic           s1_ready;
   logic           s2_ready;
   logic           rsp_ok;
   logic           rsp_port_zero;
   logic           rsp_fields_zero;
   logic           rsp_all_space;
   logic           rsp_size_legal;

   // Configuration register, with the limit minus one kept alongside it.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff    <= USER_LIMIT_RESET;
         limit_m1_ff <= USER_LIMIT_RESET - 64'd1;
      end else if (csr_we) begin
         limit_ff    <= csr_wdata;
         limit_m1_ff <= csr_wdata - 64'd1;
      end
   end

   // Stage flow control.
   assign s2_ready       = !rsp_valid_ff || rsp_port.ready;
   assign s1_ready       = !s1_valid_ff || s2_ready;
   assign req_port.ready = s1_ready;

   always_comb begin
      s1_valid_in  = s1_ready ? req_port.valid : s1_valid_ff;
      rsp_valid_in = s2_ready ? s1_valid_ff : rsp_valid_ff;
   end

   always_comb begin
      req_data.instr_address = req_port.instr_address;
      req_data.opcode_byte0  = req_port.opcode_byte0;
      req_data.opcode_byte1  = req_port.opcode_byte1;
      req_data.opcode_byte2  = req_port.opcode_byte2;
      req_data.dx_value      = req_port.dx_value;
   end

   // Valid bits of both stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers load only when their stage advances.
   always_ff @(posedge clock) begin
      if (s1_ready && req_port.valid) begin
         s1_data_ff <= req_data;
      end
      if (s2_ready && s1_valid_ff) begin
         rsp_data_ff <= dec_rsp;
      end
   end

   x86pio_decode #(
      .NUM_PORTS     (NUM_PORTS)
   ) u_decode (
      .req           (s1_data_ff),
      .user_limit    (limit_ff),
      .user_limit_m1 (limit_m1_ff),
      .rsp           (dec_rsp)
   );

   // Result outputs.
   assign rsp_port.valid     = rsp_valid_ff;
   assign rsp_port.decode_ok = rsp_data_ff.decode_ok;
   assign rsp_port.io_port   = rsp_data_ff.io_port;
   assign rsp_port.size_log2 = rsp_data_ff.size_log2;

   // Properties of the presented result.
   assign rsp_ok          = rsp_data_ff.decode_ok;
   assign rsp_port_zero   = rsp_data_ff.io_port == 16'd0;
   assign rsp_fields_zero = rsp_port_zero && (rsp_data_ff.size_log2 == SIZE_BYTE);
   assign rsp_all_space   = rsp_data_ff.size_log2 == SIZE_ALL;
   assign rsp_size_legal  = (rsp_data_ff.size_log2 == SIZE_BYTE) ||
                            (rsp_data_ff.size_log2 == SIZE_WORD) ||
                            (rsp_data_ff.size_log2 == SIZE_DWORD) || rsp_all_space;

   // A failed decode carries zero port and size.
   `X86_ASSERT_IMPLIES(a_fail_zero, clock, reset, rsp_valid_ff && !rsp_ok, rsp_fields_zero)
   // A successful decode has one of the four size codes.
   `X86_ASSERT_IMPLIES(a_size_code, clock, reset, rsp_valid_ff && rsp_ok, rsp_size_legal)
   // The whole-space result always names port zero.
   `X86_ASSERT_IMPLIES(a_all_port0, clock, reset, rsp_valid_ff && rsp_all_space, rsp_port_zero)
   // An item in the input register moves to the result register when it has room.
   `X86_ASSERT_NEXT(a_advance, clock, reset, s1_valid_ff && s2_ready, rsp_valid_ff)
   // The shadow limit stays one below the configured limit.
   `X86_ASSERT_IMPLIES(a_limit_m1, clock, reset, 1'b1, limit_m1_ff == (limit_ff - 64'd1))

endmodule
